// ===== hdl/bvie_pkg.sv =====
// types, constants and mask helper shared by the bit vector insert/erase core
`default_nettype none

package bvie_pkg;

	localparam int unsigned CAPACITY = 256;
	localparam int unsigned ADDR_W   = $clog2(CAPACITY);
	localparam int unsigned LEN_W    = ADDR_W + 1;

	typedef enum logic [2:0] {
		OP_GET    = 3'd0,
		OP_SET    = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_PUSH   = 3'd4,
		OP_POP    = 3'd5,
		OP_RESIZE = 3'd6,
		OP_CLEAR  = 3'd7
	} opcode_t;

	typedef struct packed {
		opcode_t          opcode;
		logic [LEN_W-1:0] bit_index;
		logic             bit_value;
	} cmd_t;

	typedef struct packed {
		logic             read_bit;
		logic [LEN_W-1:0] current_length;
		logic             error_flag;
	} rsp_t;

	typedef logic [CAPACITY-1:0] store_t;

	// bits strictly below position n set
	function automatic store_t low_mask(input logic [LEN_W-1:0] n);
		store_t m;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			m[i] = (LEN_W'(i) < n);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bvie_cmd_reg.sv =====
// command input register with valid/ready handshake
`default_nettype none

module bvie_cmd_reg
	import bvie_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	input  wire logic take,
	output logic      valid_s1,
	output cmd_t      cmd_s1
);

	assign cmd_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bvie_exec.sv =====
// bit store and length registers with single-pass command update
`default_nettype none

module bvie_exec
	import bvie_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire cmd_t             cmd_s1,
	output rsp_t                  result,
	output logic [LEN_W-1:0]      length
);

	store_t           store_q;
	logic [LEN_W-1:0] len_q;
	store_t           store_d;
	logic [LEN_W-1:0] len_d;
	logic             rd;
	logic             err;

	logic [LEN_W-1:0]  idx;
	logic [ADDR_W-1:0] addr;
	logic [LEN_W-1:0]  len_m1;
	logic [LEN_W-1:0]  idx_p1;
	logic              in_range;
	logic              full;
	logic              empty;
	store_t            mask_idx;
	store_t            mask_idx1;
	store_t            mask_last;

	assign idx       = cmd_s1.bit_index;
	assign addr      = idx[ADDR_W-1:0];
	assign len_m1    = len_q - LEN_W'(1);
	assign idx_p1    = idx + LEN_W'(1);
	assign in_range  = idx < len_q;
	assign full      = (len_q == LEN_W'(CAPACITY));
	assign empty     = (len_q == '0);
	assign mask_idx  = low_mask(idx);
	assign mask_idx1 = low_mask(idx_p1);
	assign mask_last = low_mask(len_m1);

	always_comb begin
		store_d = store_q;
		len_d   = len_q;
		rd      = 1'b0;
		err     = 1'b0;
		unique case (cmd_s1.opcode)
			OP_GET: begin
				if (in_range) begin
					rd = store_q[addr];
				end else begin
					err = 1'b1;
				end
			end
			OP_SET: begin
				if (in_range) begin
					store_d[addr] = cmd_s1.bit_value;
				end else begin
					err = 1'b1;
				end
			end
			OP_INSERT: begin
				if (idx > len_q || full) begin
					err = 1'b1;
				end else begin
					store_d = (store_q & mask_idx) | ((store_q << 1) & ~mask_idx1)
						| (store_t'(cmd_s1.bit_value) << addr);
					len_d = len_q + LEN_W'(1);
				end
			end
			OP_ERASE: begin
				if (in_range) begin
					store_d = (store_q & mask_idx) | ((store_q >> 1) & ~mask_idx);
					len_d   = len_m1;
				end else begin
					err = 1'b1;
				end
			end
			OP_PUSH: begin
				if (full) begin
					err = 1'b1;
				end else begin
					store_d[len_q[ADDR_W-1:0]] = cmd_s1.bit_value;
					len_d = len_q + LEN_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					rd      = store_q[len_m1[ADDR_W-1:0]];
					store_d = store_q & mask_last;
					len_d   = len_m1;
				end
			end
			OP_RESIZE: begin
				if (idx > LEN_W'(CAPACITY)) begin
					err = 1'b1;
				end else begin
					store_d = store_q & mask_idx;
					len_d   = idx;
				end
			end
			OP_CLEAR: begin
				store_d = '0;
				len_d   = '0;
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	assign result.read_bit       = rd;
	assign result.current_length = len_d;
	assign result.error_flag     = err;
	assign length                = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			len_q   <= '0;
		end else if (take) begin
			store_q <= store_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bvie_rsp_reg.sv =====
// result output register with valid/ready handshake
`default_nettype none

module bvie_rsp_reg
	import bvie_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_s1,
	input  wire rsp_t result,
	output logic      take,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	assign take = valid_s1 && (!rsp_valid || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (take) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp <= result;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bit_vector_insert_erase_core.sv =====
// top level of the bit vector insert/erase core
`default_nettype none

// Variable-length bit vector of up to CAPACITY bits, position 0 first. Each
// command (get, set, insert, erase, push, pop, resize, clear) gives exactly one
// response with the read bit, the length after the command and an error flag;
// a refused command leaves the vector unchanged. One command per clock cycle
// is sustained while responses are taken; a response is presented from the
// response register after its command has passed the command register, and is
// held while rsp_ready is low, which in turn stalls cmd_ready. The rate rests
// on the single-pass update of the full bit store register from the registered
// command, done with masks and one-place shifts.
module bit_vector_insert_erase_core
	import bvie_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic             take;
	logic             valid_s1;
	cmd_t             cmd_s1;
	rsp_t             result;
	logic [LEN_W-1:0] length;

	bvie_cmd_reg u_cmd_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.take      (take),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1)
	);

	bvie_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cmd_s1 (cmd_s1),
		.result (result),
		.length (length)
	);

	bvie_rsp_reg u_rsp_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.take      (take),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.current_length <= LEN_W'(CAPACITY))
		else $error("response length beyond capacity");

	a_err_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		take && result.error_flag |=> length == $past(length))
		else $error("refused command changed the length");

	a_read_only_get_pop: assert property (@(posedge clk) disable iff (!arst_n)
		take && result.read_bit |-> cmd_s1.opcode == OP_GET || cmd_s1.opcode == OP_POP)
		else $error("read bit set on a command that reads nothing");

	a_take_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid && rsp.current_length == length)
		else $error("executed command left no matching response");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the bit vector insert/erase core: directed rows, then random checked commands
`timescale 1ns / 100ps

module tb_top
	import bvie_pkg::*;
();

	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t r;
	} dir_row_t;

	localparam int DIR_ROWS   = 24;
	localparam int RAND_ITEMS = 1430;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic rsp_ready = 1'b0;
	cmd_t cmd       = '0;
	logic cmd_ready;
	logic rsp_valid;
	rsp_t rsp;

	store_t           bv_bits;
	logic [LEN_W-1:0] bv_len;
	rsp_t             expected_rsp_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int rsp_checked = 0;
	int refused_count = 0;
	int full_hits = 0;
	int op_count[8];

	dir_row_t dir_rows[DIR_ROWS];

	bit_vector_insert_erase_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	// updates the predicted vector and returns the response for one command
	function automatic rsp_t bv_apply(input cmd_t c);
		rsp_t   r;
		store_t below;
		r = '0;
		below = (store_t'(1) << c.bit_index) - store_t'(1);
		case (c.opcode)
			OP_GET: begin
				if (c.bit_index < bv_len) r.read_bit = bv_bits[c.bit_index];
				else r.error_flag = 1'b1;
			end
			OP_SET: begin
				if (c.bit_index < bv_len) bv_bits[c.bit_index] = c.bit_value;
				else r.error_flag = 1'b1;
			end
			OP_INSERT: begin
				if (c.bit_index > bv_len || bv_len >= CAPACITY) begin
					r.error_flag = 1'b1;
				end else begin
					bv_bits = (bv_bits & below) | ((bv_bits & ~below) << 1)
						| (store_t'(c.bit_value) << c.bit_index);
					bv_len = bv_len + 1'b1;
				end
			end
			OP_ERASE: begin
				if (c.bit_index >= bv_len) begin
					r.error_flag = 1'b1;
				end else begin
					bv_bits = (bv_bits & below) | ((bv_bits >> 1) & ~below);
					bv_len = bv_len - 1'b1;
				end
			end
			OP_PUSH: begin
				if (bv_len >= CAPACITY) begin
					r.error_flag = 1'b1;
				end else begin
					bv_bits[bv_len] = c.bit_value;
					bv_len = bv_len + 1'b1;
				end
			end
			OP_POP: begin
				if (bv_len == 0) begin
					r.error_flag = 1'b1;
				end else begin
					bv_len = bv_len - 1'b1;
					r.read_bit = bv_bits[bv_len];
					bv_bits[bv_len] = 1'b0;
				end
			end
			OP_RESIZE: begin
				if (c.bit_index > CAPACITY) begin
					r.error_flag = 1'b1;
				end else begin
					bv_bits = bv_bits & below;
					bv_len = c.bit_index;
				end
			end
			default: begin
				bv_bits = '0;
				bv_len = '0;
			end
		endcase
		r.current_length = bv_len;
		return r;
	endfunction

	function automatic dir_row_t row(input opcode_t op, input int idx, input bit val,
		input bit typed, input bit rd, input int len, input bit err);
		dir_row_t d;
		d.c = '{opcode: op, bit_index: LEN_W'(idx), bit_value: val};
		d.typed = typed;
		d.r = '{read_bit: rd, current_length: LEN_W'(len), error_flag: err};
		return d;
	endfunction

	// mostly in-range commands so the vector grows, fills and shrinks; some noise
	function automatic cmd_t pick_random_cmd();
		cmd_t c;
		int   r;
		int   hi;
		r = $urandom_range(99);
		hi = (bv_len == 0) ? 0 : int'(bv_len) - 1;
		c.bit_value = 1'($urandom_range(1));
		c.bit_index = LEN_W'($urandom_range(hi));
		if (r < 12) c.opcode = OP_GET;
		else if (r < 24) c.opcode = OP_SET;
		else if (r < 40) begin
			c.opcode = OP_INSERT;
			c.bit_index = LEN_W'($urandom_range(bv_len));
		end else if (r < 52) c.opcode = OP_ERASE;
		else if (r < 66) c.opcode = OP_PUSH;
		else if (r < 76) c.opcode = OP_POP;
		else if (r < 84) begin
			c.opcode = OP_RESIZE;
			if ($urandom_range(3) == 0) c.bit_index = LEN_W'(CAPACITY - $urandom_range(1));
			else c.bit_index = LEN_W'($urandom_range(CAPACITY));
		end else if (r < 87) c.opcode = OP_CLEAR;
		else begin
			c.opcode = opcode_t'($urandom_range(7));
			c.bit_index = LEN_W'($urandom_range(2 ** LEN_W - 1));
		end
		return c;
	endfunction

	// one command transfer; called at a falling edge, returns at a falling edge
	task automatic issue(input cmd_t c, input bit typed, input rsp_t typed_rsp);
		rsp_t want;
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		want = bv_apply(c);
		if (typed) want = typed_rsp;
		op_count[c.opcode]++;
		if (want.error_flag) refused_count++;
		if (want.current_length == CAPACITY) full_hits++;
		@(negedge clk);
		expected_rsp_q = {expected_rsp_q, want};
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: response %p with none expected", $time, rsp);
				mismatch_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				rsp_checked++;
				if (rsp.read_bit !== want.read_bit) begin
					$display("%0t: read_bit expected %0b actual %0b", $time,
						want.read_bit, rsp.read_bit);
					mismatch_count++;
				end
				if (rsp.current_length !== want.current_length) begin
					$display("%0t: current_length expected %0d actual %0d", $time,
						want.current_length, rsp.current_length);
					mismatch_count++;
				end
				if (rsp.error_flag !== want.error_flag) begin
					$display("%0t: error_flag expected %0b actual %0b", $time,
						want.error_flag, rsp.error_flag);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		dir_rows = '{
			row(OP_GET,      0, 0, 1, 0,   0, 1),
			row(OP_POP,      0, 0, 1, 0,   0, 1),
			row(OP_SET,      0, 1, 1, 0,   0, 1),
			row(OP_ERASE,    0, 0, 1, 0,   0, 1),
			row(OP_INSERT,   1, 1, 1, 0,   0, 1),
			row(OP_RESIZE, 257, 0, 1, 0,   0, 1),
			row(OP_INSERT,   0, 1, 1, 0,   1, 0),
			row(OP_PUSH,     0, 0, 1, 0,   2, 0),
			row(OP_PUSH,     0, 1, 1, 0,   3, 0),
			row(OP_INSERT,   1, 1, 0, 0,   0, 0),
			row(OP_GET,      1, 0, 0, 0,   0, 0),
			row(OP_ERASE,    0, 0, 0, 0,   0, 0),
			row(OP_GET,      2, 0, 0, 0,   0, 0),
			row(OP_POP,      0, 0, 0, 0,   0, 0),
			row(OP_RESIZE, 256, 0, 1, 0, 256, 0),
			row(OP_INSERT, 256, 1, 1, 0, 256, 1),
			row(OP_PUSH,     0, 1, 1, 0, 256, 1),
			row(OP_GET,    255, 0, 1, 0, 256, 0),
			row(OP_SET,    255, 1, 1, 0, 256, 0),
			row(OP_POP,      0, 0, 1, 1, 255, 0),
			row(OP_RESIZE, 511, 1, 1, 0, 255, 1),
			row(OP_GET,    255, 0, 1, 0, 255, 1),
			row(OP_RESIZE,   0, 0, 1, 0,   0, 0),
			row(OP_CLEAR,  511, 1, 1, 0,   0, 0)
		};
		bv_bits = '0;
		bv_len = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 61;
		foreach (dir_rows[i]) issue(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 61 : 0;
			recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 30 : 0;
			for (int n = 0; n < RAND_ITEMS / 3; n++) issue(pick_random_cmd(), 1'b0, '0);
			// sender holds off until every response is back
			drain();
		end
		repeat (8) @(negedge clk);

		$display("checked %0d responses, %0d refused commands, length at capacity %0d times",
			rsp_checked, refused_count, full_hits);
		$display("commands get/set/ins/era/push/pop/resize/clear: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
			op_count[OP_GET], op_count[OP_SET], op_count[OP_INSERT], op_count[OP_ERASE],
			op_count[OP_PUSH], op_count[OP_POP], op_count[OP_RESIZE], op_count[OP_CLEAR]);
		if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bvie_pkg.sv
hdl/bvie_cmd_reg.sv
hdl/bvie_exec.sv
hdl/bvie_rsp_reg.sv
hdl/bit_vector_insert_erase_core.sv
test/tb_top.sv
